>>> rtl/core/point_projection_unit_defines.svh
// assertion macros for the point projection unit
`ifndef POINT_PROJECTION_UNIT_DEFINES_SVH
`define POINT_PROJECTION_UNIT_DEFINES_SVH

// condition holds at every edge outside reset
`define PPU_CHECK_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define PPU_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ppu_pkg.sv
// shared types and constants of the point projection unit
package ppu_pkg;

    typedef logic [2:0]  t_mode;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;
    typedef logic [1:0]  t_cls;

    typedef struct packed {
        logic        [15:0] scale;
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
        logic signed [15:0] off_h;
        logic signed [15:0] off_v;
    } t_cfg;

    localparam t_mode MODE_ISO = 3'd0;
    localparam t_mode MODE_TP  = 3'd1;
    localparam t_mode MODE_XV  = 3'd2;
    localparam t_mode MODE_YV  = 3'd3;
    localparam t_mode MODE_ZV  = 3'd4;

    localparam t_cls CLS_NONE = 2'd0;
    localparam t_cls CLS_ISO  = 2'd1;
    localparam t_cls CLS_TP   = 2'd2;
    localparam t_cls CLS_AXIS = 2'd3;

    localparam t_cfg_idx REG_SCALE = 3'd0;
    localparam t_cfg_idx REG_COS   = 3'd1;
    localparam t_cfg_idx REG_SIN   = 3'd2;
    localparam t_cfg_idx REG_OFFH  = 3'd3;
    localparam t_cfg_idx REG_OFFV  = 3'd4;

    localparam t_cfg_data RST_SCALE = 16'd256;
    localparam t_cfg_data RST_COS   = 16'd14189;
    localparam t_cfg_data RST_SIN   = 16'd8192;

    localparam int TP_FOCAL   = 500;
    localparam int TP_DIST    = 2560;
    localparam int TP_MIN     = 256;
    localparam int TP_X_BIAS  = 256;
    localparam int TP_COS     = 15652;
    localparam int TP_SIN     = 4842;
    localparam int FRAC_SHIFT = 14;
    localparam int ISO_FRAC   = 30;
    localparam int ISO_ROUND  = (1 << ISO_FRAC) - 1;
    localparam int FQ_DEPTH   = 4;

endpackage

>>> rtl/core/ppu_front.sv
// front end: accepts points, decodes the mode and prepares operands
module ppu_front #(
    parameter int CW = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  ppu_pkg::t_mode          i_mode,
    input  logic signed [CW-1:0]    i_coord_x,
    input  logic signed [CW-1:0]    i_coord_y,
    input  logic signed [CW-1:0]    i_coord_z,
    output logic                    o_vld,
    input  logic                    i_q_ready,
    output ppu_pkg::t_cls           o_cls,
    output logic signed [CW:0]      o_xp,
    output logic signed [CW-1:0]    o_y,
    output logic signed [CW-1:0]    o_z,
    output logic signed [CW:0]      o_diff,
    output logic signed [CW:0]      o_sum,
    output logic        [CW:0]      o_den,
    output logic signed [CW:0]      o_axh,
    output logic signed [CW:0]      o_axv
);
    import ppu_pkg::*;

    localparam int CW1 = CW + 1;
    localparam int YW  = CW + 2;

    logic                  w_acc;
    t_cls                  w_cls;
    logic signed [CW1-1:0] w_x1;
    logic signed [CW1-1:0] w_y1;
    logic signed [CW1-1:0] w_z1;
    logic signed [CW1-1:0] w_axh;
    logic signed [CW1-1:0] w_axv;
    logic signed [YW-1:0]  w_yp;
    logic        [CW1-1:0] w_den;

    logic                  r_vld;
    t_cls                  r_cls;
    logic signed [CW1-1:0] r_xp;
    logic signed [CW-1:0]  r_y;
    logic signed [CW-1:0]  r_z;
    logic signed [CW1-1:0] r_diff;
    logic signed [CW1-1:0] r_sum;
    logic        [CW1-1:0] r_den;
    logic signed [CW1-1:0] r_axh;
    logic signed [CW1-1:0] r_axv;

    assign o_ready = !r_vld || i_q_ready;
    assign w_acc   = i_valid && o_ready;

    assign w_x1  = CW1'(i_coord_x);
    assign w_y1  = CW1'(i_coord_y);
    assign w_z1  = CW1'(i_coord_z);
    assign w_yp  = YW'(i_coord_y) + YW'(TP_DIST);
    assign w_den = (w_yp < YW'(TP_MIN)) ? CW1'(TP_MIN) : w_yp[CW1-1:0];

    always_comb begin
        case (i_mode)
            MODE_ISO: begin
                w_cls = CLS_ISO;
                w_axh = '0;
                w_axv = '0;
            end
            MODE_TP: begin
                w_cls = CLS_TP;
                w_axh = '0;
                w_axv = '0;
            end
            MODE_XV: begin
                w_cls = CLS_AXIS;
                w_axh = -w_y1;
                w_axv = -w_z1;
            end
            MODE_YV: begin
                w_cls = CLS_AXIS;
                w_axh = -w_x1;
                w_axv = -w_z1;
            end
            MODE_ZV: begin
                w_cls = CLS_AXIS;
                w_axh = w_x1;
                w_axv = w_y1;
            end
            default: begin
                w_cls = CLS_NONE;
                w_axh = '0;
                w_axv = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_q_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cls  <= w_cls;
            r_xp   <= w_x1 + CW1'(TP_X_BIAS);
            r_y    <= i_coord_y;
            r_z    <= i_coord_z;
            r_diff <= w_x1 - w_y1;
            r_sum  <= w_x1 + w_y1;
            r_den  <= w_den;
            r_axh  <= w_axh;
            r_axv  <= w_axv;
        end
    end

    assign o_vld  = r_vld;
    assign o_cls  = r_cls;
    assign o_xp   = r_xp;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_diff = r_diff;
    assign o_sum  = r_sum;
    assign o_den  = r_den;
    assign o_axh  = r_axh;
    assign o_axv  = r_axv;

endmodule

>>> rtl/core/ppu_fifo.sv
// short queue between front and back end
module ppu_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_in_ready,
    input  logic [W-1:0] i_data,
    output logic         o_out_vld,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_in_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_out_vld  = (r_cnt != '0);
    assign w_wr       = i_push && o_in_ready;
    assign w_rd       = i_pop && o_out_vld;
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/ppu_div.sv
// pipelined restoring divider, one quotient bit per stage
module ppu_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] r_rem [QW];
    logic [RW-1:0] r_dv  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] dv_in;
        logic [QW-1:0] q_in;
        logic [RW-1:0] trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in = RW'(i_num);
            assign dv_in  = RW'(i_den);
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign dv_in  = r_dv[j-1];
            assign q_in   = r_q[j-1];
        end

        assign trial = dv_in << (QW - 1 - j);
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? rem_in - trial : rem_in;
                r_dv[j]  <= dv_in;
                r_q[j]   <= q_in | (take ? (QW'(1) << (QW - 1 - j)) : '0);
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

>>> rtl/core/ppu_back.sv
// back end: multiply and divide pipeline with output register
module ppu_back #(
    parameter int CW = 24,
    parameter int PW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppu_pkg::t_cfg         i_cfg,
    input  logic                  i_vld,
    output logic                  o_pop,
    input  ppu_pkg::t_cls         i_cls,
    input  logic signed [CW:0]    i_xp,
    input  logic signed [CW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_z,
    input  logic signed [CW:0]    i_diff,
    input  logic signed [CW:0]    i_sum,
    input  logic        [CW:0]    i_den,
    input  logic signed [CW:0]    i_axh,
    input  logic signed [CW:0]    i_axv,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [PW-1:0]  o_pixel_x,
    output logic signed [PW-1:0]  o_pixel_y,
    output logic                  o_clipped
);
    import ppu_pkg::*;

    localparam int DENW = CW + 1;
    localparam int MW   = CW + 17;
    localparam int OW   = CW + 18;
    localparam int PRW  = CW + 35;
    localparam int VW   = CW + 36;
    localparam int NXW  = CW + 20;
    localparam int NYW  = CW + 34;
    localparam int DYW  = DENW + FRAC_SHIFT;
    localparam int CXW  = (NXW > DENW + PW) ? NXW : DENW + PW;
    localparam int CYW  = (NYW > DYW + PW) ? NYW : DYW + PW;
    localparam int SW   = (CW + 6 > PW + 1) ? CW + 6 : PW + 1;
    localparam int L    = PW + 5;
    localparam logic signed [SW-1:0] P_HI = SW'((1 << (PW - 1)) - 1);
    localparam logic signed [SW-1:0] P_LO = SW'(-(1 << (PW - 1)));

    function automatic logic [PW:0] sat_fn(input logic signed [SW-1:0] v);
        logic [PW:0] res;
        if (v > P_HI) begin
            res = {1'b1, P_HI[PW-1:0]};
        end else if (v < P_LO) begin
            res = {1'b1, P_LO[PW-1:0]};
        end else begin
            res = {1'b0, v[PW-1:0]};
        end
        return res;
    endfunction

    logic w_en;
    logic [L-1:0] r_vld;

    // stage 1
    t_cls                  r_cls1;
    logic signed [MW-1:0]  r_mhx;
    logic signed [MW-1:0]  r_mhy;
    logic signed [CW-1:0]  r_z1;
    logic signed [CW:0]    r_axh1;
    logic signed [CW:0]    r_axv1;
    logic signed [NXW-1:0] r_tax;
    logic signed [NXW-1:0] r_tbx;
    logic signed [NYW-1:0] r_tzy;
    logic signed [NYW-1:0] r_toy;
    logic [DENW-1:0]       r_den1;
    // stage 2
    t_cls                  r_cls2;
    logic signed [OW-1:0]  r_oph;
    logic signed [OW-1:0]  r_opv;
    logic signed [NXW-1:0] r_numx;
    logic signed [NYW-1:0] r_numy;
    logic [DENW-1:0]       r_den2;
    // stage 3
    t_cls                  r_cls3;
    logic signed [PRW-1:0] r_prh;
    logic signed [PRW-1:0] r_prv;
    logic [NXW-1:0]        r_magx;
    logic [NYW-1:0]        r_magy;
    logic                  r_negx;
    logic                  r_negy;
    logic                  r_satx;
    logic                  r_saty;
    logic [DENW-1:0]       r_den3;
    logic signed [NXW-1:0] w_absx;
    logic signed [NYW-1:0] w_absy;
    // divider side line
    t_cls                  r_d_cls  [PW];
    logic signed [PRW-1:0] r_d_prh  [PW];
    logic signed [PRW-1:0] r_d_prv  [PW];
    logic                  r_d_negx [PW];
    logic                  r_d_negy [PW];
    logic                  r_d_satx [PW];
    logic                  r_d_saty [PW];
    logic [PW-1:0]         w_quox;
    logic [PW-1:0]         w_quoy;
    // finish stage
    t_cls                  r_f_cls;
    logic signed [VW-1:0]  r_f_vh;
    logic signed [VW-1:0]  r_f_vv;
    logic signed [PW:0]    r_f_qh;
    logic signed [PW:0]    r_f_qv;
    logic                  r_f_negx;
    logic                  r_f_negy;
    logic                  r_f_satx;
    logic                  r_f_saty;
    logic signed [VW-1:0]  w_th;
    logic signed [VW-1:0]  w_tv;
    logic [PW:0]           w_mh;
    logic [PW:0]           w_mv;
    logic [PW:0]           w_dh;
    logic [PW:0]           w_dv;
    logic [PW:0]           n_h;
    logic [PW:0]           n_v;
    // output register
    logic signed [PW-1:0]  r_px;
    logic signed [PW-1:0]  r_py;
    logic                  r_clip;

    assign w_en  = !r_vld[L-1] || i_ready;
    assign o_pop = i_vld && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cls1 <= i_cls;
            r_mhx  <= MW'(i_diff) * MW'(i_cfg.cosine);
            r_mhy  <= MW'(i_sum) * MW'(i_cfg.sine);
            r_z1   <= i_z;
            r_axh1 <= i_axh;
            r_axv1 <= i_axv;
            r_tax  <= NXW'(i_xp) * NXW'(TP_FOCAL);
            r_tbx  <= NXW'(i_cfg.off_h) * NXW'(signed'({1'b0, i_den}));
            r_tzy  <= NYW'(i_z) * NYW'(TP_COS) + NYW'(i_y) * NYW'(TP_SIN);
            r_toy  <= NYW'(i_cfg.off_v) * NYW'(signed'({1'b0, i_den}));
            r_den1 <= i_den;

            r_cls2 <= r_cls1;
            if (r_cls1 == CLS_ISO) begin
                r_oph <= OW'(r_mhx);
                r_opv <= OW'(r_mhy) - (OW'(r_z1) <<< FRAC_SHIFT);
            end else begin
                r_oph <= OW'(r_axh1) <<< FRAC_SHIFT;
                r_opv <= OW'(r_axv1) <<< FRAC_SHIFT;
            end
            r_numx <= r_tax + r_tbx;
            r_numy <= (r_toy <<< FRAC_SHIFT) - r_tzy * NYW'(TP_FOCAL);
            r_den2 <= r_den1;

            r_cls3 <= r_cls2;
            r_prh  <= PRW'(r_oph) * PRW'(signed'({1'b0, i_cfg.scale}));
            r_prv  <= PRW'(r_opv) * PRW'(signed'({1'b0, i_cfg.scale}));
            r_magx <= unsigned'(w_absx);
            r_magy <= unsigned'(w_absy);
            r_negx <= r_numx[NXW-1];
            r_negy <= r_numy[NYW-1];
            r_satx <= CXW'(unsigned'(w_absx)) >= (CXW'(r_den2) << PW);
            r_saty <= CYW'(unsigned'(w_absy)) >= (CYW'(r_den2) << (PW + FRAC_SHIFT));
            r_den3 <= r_den2;
        end
    end

    assign w_absx = r_numx[NXW-1] ? -r_numx : r_numx;
    assign w_absy = r_numy[NYW-1] ? -r_numy : r_numy;

    ppu_div #(
        .NW (NXW),
        .DW (DENW),
        .QW (PW)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_magx),
        .i_den (r_den3),
        .o_quo (w_quox)
    );

    ppu_div #(
        .NW (NYW),
        .DW (DYW),
        .QW (PW)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_magy),
        .i_den ({r_den3, {FRAC_SHIFT{1'b0}}}),
        .o_quo (w_quoy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_cls[0]  <= r_cls3;
            r_d_prh[0]  <= r_prh;
            r_d_prv[0]  <= r_prv;
            r_d_negx[0] <= r_negx;
            r_d_negy[0] <= r_negy;
            r_d_satx[0] <= r_satx;
            r_d_saty[0] <= r_saty;
            for (int k = 1; k < PW; k++) begin
                r_d_cls[k]  <= r_d_cls[k-1];
                r_d_prh[k]  <= r_d_prh[k-1];
                r_d_prv[k]  <= r_d_prv[k-1];
                r_d_negx[k] <= r_d_negx[k-1];
                r_d_negy[k] <= r_d_negy[k-1];
                r_d_satx[k] <= r_d_satx[k-1];
                r_d_saty[k] <= r_d_saty[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_cls  <= r_d_cls[PW-1];
            r_f_vh   <= VW'(r_d_prh[PW-1]) + (VW'(i_cfg.off_h) <<< ISO_FRAC);
            r_f_vv   <= VW'(r_d_prv[PW-1]) + (VW'(i_cfg.off_v) <<< ISO_FRAC);
            r_f_qh   <= r_d_negx[PW-1] ? -signed'({1'b0, w_quox}) : signed'({1'b0, w_quox});
            r_f_qv   <= r_d_negy[PW-1] ? -signed'({1'b0, w_quoy}) : signed'({1'b0, w_quoy});
            r_f_negx <= r_d_negx[PW-1];
            r_f_negy <= r_d_negy[PW-1];
            r_f_satx <= r_d_satx[PW-1];
            r_f_saty <= r_d_saty[PW-1];
        end
    end

    // truncate toward zero, then saturate
    assign w_th = r_f_vh + (r_f_vh[VW-1] ? VW'(ISO_ROUND) : '0);
    assign w_tv = r_f_vv + (r_f_vv[VW-1] ? VW'(ISO_ROUND) : '0);
    assign w_mh = sat_fn(SW'(w_th >>> ISO_FRAC));
    assign w_mv = sat_fn(SW'(w_tv >>> ISO_FRAC));
    assign w_dh = r_f_satx ? {1'b1, (r_f_negx ? P_LO[PW-1:0] : P_HI[PW-1:0])}
                           : sat_fn(SW'(r_f_qh));
    assign w_dv = r_f_saty ? {1'b1, (r_f_negy ? P_LO[PW-1:0] : P_HI[PW-1:0])}
                           : sat_fn(SW'(r_f_qv));

    always_comb begin
        case (r_f_cls)
            CLS_ISO, CLS_AXIS: begin
                n_h = w_mh;
                n_v = w_mv;
            end
            CLS_TP: begin
                n_h = w_dh;
                n_v = w_dv;
            end
            default: begin
                n_h = '0;
                n_v = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px   <= n_h[PW-1:0];
            r_py   <= n_v[PW-1:0];
            r_clip <= n_h[PW] || n_v[PW];
        end
    end

    assign o_valid   = r_vld[L-1];
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_clipped = r_clip;

endmodule

>>> rtl/core/point_projection_unit.sv
// top level of the point projection unit
//
// channel  direction  handshake                 payload
// cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
// point    in         i_valid/o_ready           i_mode, i_coord_x/y/z
// pixel    out        o_valid/i_ready           o_pixel_x, o_pixel_y, o_clipped
//
// one point per cycle sustained while i_ready is high; path: front register, queue, back pipeline
// the divider yields one quotient bit per stage for each pixel axis
// reset loads scale 256, cosine 14189, sine 8192, zero offsets; no clearing pass
// a stall on i_ready freezes the back pipeline; a 4-entry queue keeps the front accepting until full
`include "point_projection_unit_defines.svh"

module point_projection_unit #(
    parameter int COORD_WIDTH = 24,
    parameter int PIXEL_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  ppu_pkg::t_cfg_idx               i_cfg_index,
    input  ppu_pkg::t_cfg_data              i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ppu_pkg::t_mode                  i_mode,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [PIXEL_WIDTH-1:0]   o_pixel_x,
    output logic signed [PIXEL_WIDTH-1:0]   o_pixel_y,
    output logic                            o_clipped
);
    import ppu_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int CW1 = CW + 1;
    localparam int FW  = 2 + 6 * CW1 + 2 * CW;

    t_cfg r_cfg;

    logic                  w_fr_vld;
    logic                  w_q_ready;
    t_cls                  w_fr_cls;
    logic signed [CW1-1:0] w_fr_xp;
    logic signed [CW-1:0]  w_fr_y;
    logic signed [CW-1:0]  w_fr_z;
    logic signed [CW1-1:0] w_fr_diff;
    logic signed [CW1-1:0] w_fr_sum;
    logic        [CW1-1:0] w_fr_den;
    logic signed [CW1-1:0] w_fr_axh;
    logic signed [CW1-1:0] w_fr_axv;
    logic [FW-1:0]         w_q_din;
    logic [FW-1:0]         w_q_dout;
    logic                  w_q_vld;
    logic                  w_pop;
    t_cls                  w_bk_cls;
    logic signed [CW1-1:0] w_bk_xp;
    logic signed [CW-1:0]  w_bk_y;
    logic signed [CW-1:0]  w_bk_z;
    logic signed [CW1-1:0] w_bk_diff;
    logic signed [CW1-1:0] w_bk_sum;
    logic        [CW1-1:0] w_bk_den;
    logic signed [CW1-1:0] w_bk_axh;
    logic signed [CW1-1:0] w_bk_axv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale  <= RST_SCALE;
            r_cfg.cosine <= signed'(RST_COS);
            r_cfg.sine   <= signed'(RST_SIN);
            r_cfg.off_h  <= '0;
            r_cfg.off_v  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCALE: r_cfg.scale  <= i_cfg_data;
                REG_COS:   r_cfg.cosine <= signed'(i_cfg_data);
                REG_SIN:   r_cfg.sine   <= signed'(i_cfg_data);
                REG_OFFH:  r_cfg.off_h  <= signed'(i_cfg_data);
                REG_OFFV:  r_cfg.off_v  <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    ppu_front #(
        .CW (CW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_coord_z (i_coord_z),
        .o_vld     (w_fr_vld),
        .i_q_ready (w_q_ready),
        .o_cls     (w_fr_cls),
        .o_xp      (w_fr_xp),
        .o_y       (w_fr_y),
        .o_z       (w_fr_z),
        .o_diff    (w_fr_diff),
        .o_sum     (w_fr_sum),
        .o_den     (w_fr_den),
        .o_axh     (w_fr_axh),
        .o_axv     (w_fr_axv)
    );

    assign w_q_din = {w_fr_cls, w_fr_xp, w_fr_y, w_fr_z, w_fr_diff, w_fr_sum,
                      w_fr_den, w_fr_axh, w_fr_axv};

    ppu_fifo #(
        .W     (FW),
        .DEPTH (FQ_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_fr_vld),
        .o_in_ready (w_q_ready),
        .i_data     (w_q_din),
        .o_out_vld  (w_q_vld),
        .i_pop      (w_pop),
        .o_data     (w_q_dout)
    );

    assign {w_bk_cls, w_bk_xp, w_bk_y, w_bk_z, w_bk_diff, w_bk_sum,
            w_bk_den, w_bk_axh, w_bk_axv} = w_q_dout;

    ppu_back #(
        .CW (CW),
        .PW (PIXEL_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_vld     (w_q_vld),
        .o_pop     (w_pop),
        .i_cls     (w_bk_cls),
        .i_xp      (w_bk_xp),
        .i_y       (w_bk_y),
        .i_z       (w_bk_z),
        .i_diff    (w_bk_diff),
        .i_sum     (w_bk_sum),
        .i_den     (w_bk_den),
        .i_axh     (w_bk_axh),
        .i_axv     (w_bk_axv),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_clipped (o_clipped)
    );

    `PPU_CHECK_NOW(a_front_blocks, !(w_fr_vld && !w_q_ready) || !o_ready, "front took a point while queue full")
    `PPU_CHECK_NEXT(a_front_holds, i_valid && o_ready, w_fr_vld, "accepted point not held by front")
    `PPU_CHECK_NEXT(a_cfg_scale, i_cfg_valid && o_cfg_ready && i_cfg_index == REG_SCALE, r_cfg.scale == $past(i_cfg_data), "scale write lost")

endmodule
